// ===== hw/rtl/baro_pkg.sv =====
package baro_pkg;

  localparam int RawTempW  = 16;
  localparam int RawPressW = 19;
  localparam int TempW     = 16;
  localparam int PressW    = 18;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 64;
  localparam int QuotW     = 32;
  localparam int TempQuotW = 27;

  localparam logic [CfgIdxW-1:0] RegCoeffA = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCoeffB = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCoeffC = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOss    = 2'd3;

  typedef struct packed {
    logic [RawTempW-1:0]  raw_temperature;
    logic [RawPressW-1:0] raw_pressure;
  } in_beat_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_tenths;
    logic [PressW-1:0]       pressure_pa;
    logic                    calc_error;
  } out_beat_t;

endpackage

// ===== hw/rtl/baro_div.sv =====
module baro_div #(
  parameter int W = baro_pkg::QuotW
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] num_in,
  input  logic [W-1:0] den_in,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] quo_in,
  output logic [W-1:0] num_out,
  output logic [W-1:0] den_out,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] quo_out
);

  logic [W:0]   trial;
  logic [W:0]   diff;

  always_comb begin
    trial = {rem_in, num_in[W-1]};
    diff  = trial - {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_in << 1;
      den_out <= den_in;
      if (!diff[W]) begin
        rem_out <= diff[W-1:0];
        quo_out <= {quo_in[W-2:0], 1'b1};
      end else begin
        rem_out <= trial[W-1:0];
        quo_out <= {quo_in[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/barometer_compensation_top.sv =====
// Fully pipelined compensation: one reading is accepted every cycle unless the output stalls,
// and its result passes through 70 register stages. The depth is set by the two restoring
// dividers, one quotient bit per stage: 27 stages for the temperature quotient and 32 for the
// pressure quotient, plus eleven multiply and correction stages around them. A stall freezes
// the whole pipe; the input is taken whenever the output beat is not held.
module barometer_compensation_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  baro_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output baro_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [baro_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [baro_pkg::CfgDataW-1:0]       cfg_data
);

  localparam int TD = baro_pkg::TempQuotW;
  localparam int PD = baro_pkg::QuotW;

  logic [63:0] coeff_a, coeff_b;
  logic [31:0] coeff_c;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a <= '0; coeff_b <= '0; coeff_c <= '0; oss <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        baro_pkg::RegCoeffA: coeff_a <= cfg_data;
        baro_pkg::RegCoeffB: coeff_b <= cfg_data;
        baro_pkg::RegCoeffC: coeff_c <= cfg_data[31:0];
        baro_pkg::RegOss:    oss     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [16:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {coeff_a[15], coeff_a[15:0]};
  assign ac2 = {coeff_a[31], coeff_a[31:16]};
  assign ac3 = {coeff_a[47], coeff_a[47:32]};
  assign ac4 = {1'b0, coeff_a[63:48]};
  assign ac5 = {1'b0, coeff_b[15:0]};
  assign ac6 = {1'b0, coeff_b[31:16]};
  assign b1  = {coeff_b[47], coeff_b[47:32]};
  assign b2  = {coeff_b[63], coeff_b[63:48]};
  assign mc  = {coeff_c[15], coeff_c[15:0]};
  assign md  = {coeff_c[31], coeff_c[31:16]};

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: x1 product
  logic               v1;
  logic signed [34:0] s1_prod;
  logic [18:0]        s1_up;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      s1_prod <= (35'($signed({1'b0, in_data.raw_temperature})) - 35'(ac6)) * 35'(ac5);
      s1_up   <= in_data.raw_pressure;
    end
  end

  // stage 2: x1, divisor, sign handling for truncating division
  logic               v2;
  logic signed [19:0] s2_x1;
  logic [18:0]        s2_up;
  logic               s2_zero, s2_neg;
  logic [TD-1:0]      s2_num, s2_den;
  logic signed [19:0] x1_c, den_c;
  logic signed [28:0] num_c;
  always_comb begin
    x1_c  = 20'(s1_prod >>> 15);
    den_c = x1_c + 20'(md);
    num_c = 29'(mc) * 29'sd2048;
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      s2_x1   <= x1_c;
      s2_up   <= s1_up;
      s2_zero <= den_c == 0;
      s2_neg  <= num_c[28] ^ den_c[19];
      s2_num  <= num_c[28] ? TD'(-num_c) : TD'(num_c);
      s2_den  <= den_c[19] ? TD'(-den_c) : TD'(den_c);
    end
  end

  // temperature divider chain
  logic [TD-1:0] tn [TD+1], tdn [TD+1], tr [TD+1], tq [TD+1];
  logic        tv [TD+1];
  logic signed [19:0] tx1 [TD+1];
  logic [18:0] tup [TD+1];
  logic        tz [TD+1], tneg [TD+1];
  assign tn[0] = s2_num; assign tdn[0] = s2_den; assign tr[0] = '0; assign tq[0] = '0;
  assign tv[0] = v2; assign tx1[0] = s2_x1; assign tup[0] = s2_up;
  assign tz[0] = s2_zero; assign tneg[0] = s2_neg;
  for (genvar i = 0; i < TD; i++) begin : g_tdiv
    baro_div #(.W(TD)) u_div (
      .clk, .en, .num_in(tn[i]), .den_in(tdn[i]), .rem_in(tr[i]), .quo_in(tq[i]),
      .num_out(tn[i+1]), .den_out(tdn[i+1]), .rem_out(tr[i+1]), .quo_out(tq[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) tv[i+1] <= 1'b0;
      else if (en) tv[i+1] <= tv[i];
      if (en) begin
        tx1[i+1] <= tx1[i]; tup[i+1] <= tup[i]; tz[i+1] <= tz[i]; tneg[i+1] <= tneg[i];
      end
    end
  end

  // stage 3: b5, b6
  logic               v3, s3_err;
  logic signed [27:0] s3_b5, s3_b6;
  logic [18:0]        s3_up;
  logic signed [27:0] x2_c;
  always_comb x2_c = tneg[TD] ? -$signed({1'b0, tq[TD]}) : $signed({1'b0, tq[TD]});
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= tv[TD];
    if (en) begin
      s3_b5  <= 28'(tx1[TD]) + x2_c;
      s3_b6  <= 28'(tx1[TD]) + x2_c - 28'sd4000;
      s3_up  <= tup[TD];
      s3_err <= tz[TD];
    end
  end

  // stage 4: b6 square and linear terms
  logic               v4, s4_err;
  logic signed [27:0] s4_b5;
  logic signed [55:0] s4_sq;
  logic signed [44:0] s4_ac2b6, s4_ac3b6;
  logic [18:0]        s4_up;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      s4_sq    <= 56'(s3_b6) * 56'(s3_b6);
      s4_ac2b6 <= 45'(s3_b6) * 45'(ac2);
      s4_ac3b6 <= 45'(s3_b6) * 45'(ac3);
      s4_b5 <= s3_b5; s4_up <= s3_up; s4_err <= s3_err;
    end
  end

  // stage 5: products with b6sq
  logic               v5, s5_err;
  logic signed [27:0] s5_b5;
  logic signed [60:0] s5_b2sq, s5_b1sq;
  logic signed [44:0] s5_ac2b6, s5_ac3b6;
  logic [18:0]        s5_up;
  logic signed [43:0] b6sq_c;
  assign b6sq_c = 44'(s4_sq >>> 12);
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      s5_b2sq <= 61'(b6sq_c) * 61'(b2);
      s5_b1sq <= 61'(b6sq_c) * 61'(b1);
      s5_ac2b6 <= s4_ac2b6; s5_ac3b6 <= s4_ac3b6;
      s5_b5 <= s4_b5; s5_up <= s4_up; s5_err <= s4_err;
    end
  end

  // stage 6: b3 and x3 for b4
  logic               v6, s6_err;
  logic signed [27:0] s6_b5;
  logic [31:0]        s6_b3;
  logic [31:0]        s6_x3p;
  logic [18:0]        s6_up;
  logic signed [63:0] x3a_c, x3b_c, b3pre_c;
  always_comb begin
    x3a_c   = 64'(s5_b2sq >>> 11) + 64'(s5_ac2b6 >>> 11);
    b3pre_c = ((64'(ac1) * 64'sd4 + x3a_c) <<< oss) + 64'sd2;
    x3b_c   = ((64'(s5_ac3b6 >>> 13) + 64'(s5_b1sq >>> 16) + 64'sd2) >>> 2) + 64'sd32768;
  end
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      s6_b3  <= b3pre_c[33:2];
      s6_x3p <= x3b_c[31:0];
      s6_b5 <= s5_b5; s6_up <= s5_up; s6_err <= s5_err;
    end
  end

  // stage 7: b4 and b7 products
  logic               v7, s7_err;
  logic signed [27:0] s7_b5;
  logic [47:0]        s7_b4p;
  logic [47:0]        s7_b7p;
  logic [31:0]        diff_c;
  logic [15:0]        scale_c;
  always_comb begin
    diff_c  = 32'({13'b0, s6_up}) - s6_b3;
    scale_c = 16'(50000 >> oss);
  end
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      s7_b4p <= ac4[15:0] * s6_x3p;
      s7_b7p <= diff_c * scale_c;
      s7_b5 <= s6_b5; s7_err <= s6_err;
    end
  end

  // stage 8: divider operands
  logic               v8, s8_err, s8_hi;
  logic signed [27:0] s8_b5;
  logic [31:0]        s8_num, s8_den;
  logic [31:0]        b4_c, b7_c;
  always_comb begin
    b4_c = 32'(s7_b4p[31:0] >> 15);
    b7_c = s7_b7p[31:0];
  end
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      s8_hi  <= b7_c[31];
      s8_num <= b7_c[31] ? b7_c : b7_c << 1;
      s8_den <= b4_c;
      s8_err <= s7_err || (b4_c == 0);
      s8_b5  <= s7_b5;
    end
  end

  // pressure divider chain
  logic [PD-1:0] pn [PD+1], pdn [PD+1], pr [PD+1], pq [PD+1];
  logic          pv [PD+1], perr [PD+1], phi [PD+1];
  logic signed [27:0] pb5 [PD+1];
  assign pn[0] = s8_num; assign pdn[0] = s8_den; assign pr[0] = '0; assign pq[0] = '0;
  assign pv[0] = v8; assign perr[0] = s8_err; assign phi[0] = s8_hi; assign pb5[0] = s8_b5;
  for (genvar i = 0; i < PD; i++) begin : g_pdiv
    baro_div #(.W(PD)) u_div (
      .clk, .en, .num_in(pn[i]), .den_in(pdn[i]), .rem_in(pr[i]), .quo_in(pq[i]),
      .num_out(pn[i+1]), .den_out(pdn[i+1]), .rem_out(pr[i+1]), .quo_out(pq[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) pv[i+1] <= 1'b0;
      else if (en) pv[i+1] <= pv[i];
      if (en) begin
        perr[i+1] <= perr[i]; phi[i+1] <= phi[i]; pb5[i+1] <= pb5[i];
      end
    end
  end

  // stage 9: p and first correction products
  logic               v9, s9_err;
  logic signed [27:0] s9_b5;
  logic signed [33:0] s9_p;
  logic [47:0]        s9_sq;
  logic signed [47:0] s9_lin;
  logic [31:0]        q_c;
  assign q_c = phi[PD] ? {pq[PD][30:0], 1'b0} : pq[PD];
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= pv[PD];
    if (en) begin
      s9_p   <= $signed({2'b0, q_c});
      s9_sq  <= q_c[31:8] * q_c[31:8];
      s9_lin <= -48'sd7357 * $signed({16'b0, q_c});
      s9_b5 <= pb5[PD]; s9_err <= perr[PD];
    end
  end

  // stage 10: scale square term
  logic               v10, s10_err;
  logic signed [27:0] s10_b5;
  logic signed [33:0] s10_p;
  logic signed [63:0] s10_sq;
  logic signed [47:0] s10_lin;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
    if (en) begin
      s10_sq  <= $signed({16'b0, s9_sq}) * 64'sd3038;
      s10_lin <= s9_lin;
      s10_p <= s9_p; s10_b5 <= s9_b5; s10_err <= s9_err;
    end
  end

  // stage 11: output register
  logic signed [63:0] pf_c;
  logic signed [27:0] t_c;
  baro_pkg::out_beat_t out_data_next;
  always_comb begin
    pf_c = 64'(s10_p) + (((s10_sq >>> 16) + 64'(s10_lin >>> 16) + 64'sd3791) >>> 4);
    t_c  = (s10_b5 + 28'sd8) >>> 4;
    out_data_next = '0;
    if (s10_err) begin
      out_data_next.calc_error = 1'b1;
    end else begin
      if (pf_c < 0) out_data_next.pressure_pa = '0;
      else if (pf_c > 64'sd262143) out_data_next.pressure_pa = '1;
      else out_data_next.pressure_pa = pf_c[17:0];
      if (t_c < -28'sd32768) out_data_next.temperature_tenths = 16'sh8000;
      else if (t_c > 28'sd32767) out_data_next.temperature_tenths = 16'sh7fff;
      else out_data_next.temperature_tenths = t_c[15:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v10;
    if (en) out_data <= out_data_next;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.calc_error |-> out_data.pressure_pa == 0)
    else $error("error beat carries pressure");

endmodule

// ===== bench/barometer_compensation_top_tb.sv =====
`timescale 1ns / 1ps

module barometer_compensation_top_tb;

  localparam logic [63:0] DsCoeffA = 64'h7FE5_C7D1_FFB8_0198;
  localparam logic [63:0] DsCoeffB = 64'h0004_182E_5A71_7FF5;
  localparam logic [31:0] DsCoeffC = 32'h0B34_DDF9;
  localparam int HoldCycles = 400;
  localparam int DirRows = 16;

  typedef struct packed {
    logic                reconf;
    logic [63:0]         ca;
    logic [63:0]         cb;
    logic [31:0]         cc;
    logic [1:0]          oss;
    logic [15:0]         ut;
    logic [18:0]         up;
    logic                known;
    baro_pkg::out_beat_t res;
  } dir_row_t;

  localparam baro_pkg::out_beat_t ErrBeat =
    '{temperature_tenths: '0, pressure_pa: '0, calc_error: 1'b1};
  localparam baro_pkg::out_beat_t NoBeat  = '0;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  baro_pkg::in_beat_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  baro_pkg::out_beat_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [baro_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [baro_pkg::CfgDataW-1:0] cfg_data = '0;

  logic [63:0] coeff_a = '0, coeff_b = '0;
  logic [31:0] coeff_c = '0;
  logic [1:0]  oss_cfg = '0;

  baro_pkg::out_beat_t pending_readings[$];
  int  mismatches = 0;
  bit  quiet = 0;
  bit  hold_req = 0;

  dir_row_t dir_tab [DirRows] = '{
    '{1'b0, 64'd0, 64'd0, 32'd0, 2'd0, 16'h0000, 19'h00000, 1'b1, ErrBeat},
    '{1'b0, 64'd0, 64'd0, 32'd0, 2'd0, 16'hFFFF, 19'h7FFFF, 1'b1, ErrBeat},
    '{1'b1, DsCoeffA, DsCoeffB, DsCoeffC, 2'd0, 16'd27898, 19'd23843, 1'b0, NoBeat},
    '{1'b0, DsCoeffA, DsCoeffB, DsCoeffC, 2'd0, 16'h0000, 19'h00000, 1'b0, NoBeat},
    '{1'b0, DsCoeffA, DsCoeffB, DsCoeffC, 2'd0, 16'hFFFF, 19'h7FFFF, 1'b0, NoBeat},
    '{1'b1, DsCoeffA, DsCoeffB, DsCoeffC, 2'd3, 16'd27898, 19'h7FFFF, 1'b0, NoBeat},
    '{1'b0, DsCoeffA, DsCoeffB, DsCoeffC, 2'd3, 16'h0000, 19'h00000, 1'b0, NoBeat},
    '{1'b1, 64'h0000_C7D1_FFB8_0198, DsCoeffB, DsCoeffC, 2'd1, 16'd27898, 19'd23843,
      1'b1, ErrBeat},
    '{1'b1, DsCoeffA, 64'h0004_182E_5A71_0000, 32'h0000_DDF9, 2'd2, 16'd27898, 19'd23843,
      1'b1, ErrBeat},
    '{1'b1, DsCoeffA, 64'h0004_182E_5A71_0000, 32'h0001_8000, 2'd0, 16'd1000, 19'd5000,
      1'b0, NoBeat},
    '{1'b1, DsCoeffA, 64'h0004_182E_5A71_0000, 32'h0001_7FFF, 2'd0, 16'd1000, 19'd5000,
      1'b0, NoBeat},
    '{1'b1, '1, '1, '1, 2'd3, 16'h0000, 19'h00000, 1'b0, NoBeat},
    '{1'b0, '1, '1, '1, 2'd3, 16'hFFFF, 19'h7FFFF, 1'b0, NoBeat},
    '{1'b1, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_FFFF_FFFF, 32'h7FFF_7FFF, 2'd2,
      16'h8000, 19'h40000, 1'b0, NoBeat},
    '{1'b1, 64'h0001_8000_8000_8000, 64'h8000_8000_0001_0001, 32'h8000_8000, 2'd1,
      16'h7FFF, 19'h3FFFF, 1'b0, NoBeat},
    '{1'b0, 64'h0001_8000_8000_8000, 64'h8000_8000_0001_0001, 32'h8000_8000, 2'd1,
      16'h0001, 19'h00001, 1'b0, NoBeat}
  };

  barometer_compensation_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic baro_pkg::out_beat_t compensate(baro_pkg::in_beat_t b);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, b5, b6, b6sq, b3, p, t;
    logic [31:0] a4, tmp, b4, b7, q, up;
    baro_pkg::out_beat_t r;
    r = ErrBeat;
    ac1 = $signed(coeff_a[15:0]);
    ac2 = $signed(coeff_a[31:16]);
    ac3 = $signed(coeff_a[47:32]);
    ac4 = coeff_a[63:48];
    ac5 = coeff_b[15:0];
    ac6 = coeff_b[31:16];
    b1  = $signed(coeff_b[47:32]);
    b2  = $signed(coeff_b[63:48]);
    mc  = $signed(coeff_c[15:0]);
    md  = $signed(coeff_c[31:16]);
    ut  = b.raw_temperature;
    up  = {13'd0, b.raw_pressure};

    x1 = ((ut - ac6) * ac5) >>> 15;
    if (x1 + md == 0) return r;
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;

    b6 = b5 - 4000;
    b6sq = (b6 * b6) >>> 12;
    x1 = (b2 * b6sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_cfg) + 2) >>> 2;

    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * b6sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    a4 = ac4[31:0];
    tmp = x3[31:0] + 32'd32768;
    b4 = a4 * tmp;
    b4 = b4 >> 15;
    if (b4 == 0) return r;

    b7 = up - b3[31:0];
    b7 = b7 * (32'd50000 >> oss_cfg);
    if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
    else q = (b7 / b4) * 32'd2;
    p = longint'({32'd0, q});

    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (longint'(-7357) * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    if (p < 0) p = 0;
    if (p > 262143) p = 262143;

    t = (b5 + 8) >>> 4;
    if (t < -32768) t = -32768;
    if (t > 32767) t = 32767;

    r.temperature_tenths = t[15:0];
    r.pressure_pa = p[17:0];
    r.calc_error = 1'b0;
    return r;
  endfunction

  task automatic write_reg(input logic [baro_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic load_coeffs(input logic [63:0] a, input logic [63:0] b,
                             input logic [31:0] c, input logic [1:0] o);
    write_reg(baro_pkg::RegCoeffA, a);
    write_reg(baro_pkg::RegCoeffB, b);
    write_reg(baro_pkg::RegCoeffC, {32'd0, c});
    write_reg(baro_pkg::RegOss, {62'd0, o});
    @(posedge clk);
    cfg_we <= 1'b0;
    coeff_a = a;
    coeff_b = b;
    coeff_c = c;
    oss_cfg = o;
  endtask

  task automatic send_reading(input baro_pkg::in_beat_t b, input baro_pkg::out_beat_t e);
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(e);
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        baro_pkg::out_beat_t e;
        e = pending_readings.pop_front();
        if (out_data.temperature_tenths !== e.temperature_tenths ||
            out_data.pressure_pa !== e.pressure_pa ||
            out_data.calc_error !== e.calc_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: exp t=%0d p=%0d err=%0b got t=%0d p=%0d err=%0b",
                     e.temperature_tenths, e.pressure_pa, e.calc_error,
                     out_data.temperature_tenths, out_data.pressure_pa, out_data.calc_error);
        end
      end
    end
  end

  initial begin
    baro_pkg::in_beat_t b;
    logic [63:0] a, bw;
    logic [31:0] c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].reconf) begin
        drain();
        load_coeffs(dir_tab[i].ca, dir_tab[i].cb, dir_tab[i].cc, dir_tab[i].oss);
      end
      b.raw_temperature = dir_tab[i].ut;
      b.raw_pressure = dir_tab[i].up;
      send_reading(b, dir_tab[i].known ? dir_tab[i].res : compensate(b));
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph % 2 == 0) begin
        a  = DsCoeffA ^ ({$urandom, $urandom} & 64'h01FF_01FF_01FF_01FF);
        bw = DsCoeffB ^ ({$urandom, $urandom} & 64'h01FF_01FF_01FF_01FF);
        c  = DsCoeffC ^ ($urandom & 32'h01FF_01FF);
      end else begin
        a  = {$urandom, $urandom};
        bw = {$urandom, $urandom};
        c  = $urandom;
      end
      load_coeffs(a, bw, c, ph[1:0] ^ 2'(ph >> 2));
      quiet = (ph == 5);
      for (int n = 0; n < 105; n++) begin
        if (ph == 3 && n == 10) hold_req = 1;
        if ($urandom_range(3) == 0) b.raw_temperature = 16'($urandom);
        else b.raw_temperature = 16'(27898 + $urandom_range(0, 4000) - 2000);
        b.raw_pressure = 19'($urandom);
        send_reading(b, compensate(b));
      end
      quiet = 0;
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== barometer_compensation_top.f =====
hw/rtl/baro_pkg.sv
hw/rtl/baro_div.sv
hw/rtl/barometer_compensation_top.sv
bench/barometer_compensation_top_tb.sv
